### rtl/scsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scsa_pkg: shared types and constants
// Sizes of the weight and accumulator stores, opcodes, register indexes and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package scsa_pkg;

   localparam int KH_MAX    = 8;
   localparam int KW_MAX    = 8;
   localparam int OUT_H_MAX = 32;
   localparam int OUT_W_MAX = 32;

   localparam int W_DEPTH   = KH_MAX * KW_MAX;
   localparam int W_AW      = $clog2(W_DEPTH);
   localparam int ROW_W     = $clog2(OUT_H_MAX);
   localparam int COL_W     = $clog2(OUT_W_MAX);
   localparam int ACC_DEPTH = OUT_H_MAX * OUT_W_MAX;
   localparam int ACC_AW    = ROW_W + COL_W;
   localparam int ACC_W     = 40;
   localparam int VAL_W     = 16;
   localparam int PROD_W    = 2 * VAL_W;

   localparam int IDX_W     = 9;
   localparam int REM_W     = 4;
   localparam int TAP_W     = $clog2(KH_MAX);
   localparam int OFF_W     = W_AW + 1;
   localparam int DIV_STEPS = IDX_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS);

   localparam int KDIM_W    = 4;
   localparam int ODIM_W    = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 6;

   localparam logic [KDIM_W-1:0] KH_SAT = KDIM_W'(KH_MAX);
   localparam logic [KDIM_W-1:0] KW_SAT = KDIM_W'(KW_MAX);
   localparam logic [ODIM_W-1:0] OH_SAT = ODIM_W'(OUT_H_MAX);
   localparam logic [ODIM_W-1:0] OW_SAT = ODIM_W'(OUT_W_MAX);

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_ACC  = 2'd1,
      OP_READ = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KERNEL_H = 2'd0,
      CSR_KERNEL_W = 2'd1,
      CSR_OUT_H    = 2'd2,
      CSR_OUT_W    = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [KDIM_W-1:0] kernel_h;
      logic [KDIM_W-1:0] kernel_w;
      logic [ODIM_W-1:0] out_h;
      logic [ODIM_W-1:0] out_w;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic weight_write;
      logic div_start;
      logic div_step;
      logic tap_issue;
      logic read_issue;
      logic read_commit;
      logic clear_step;
   } dp_cmd_type;

   typedef struct packed {
      op_type opcode;
      logic   skip;
      logic   div_last;
      logic   tap_last;
      logic   pipe_busy;
      logic   rsp_free;
      logic   clear_last;
   } dp_stat_type;

endpackage
`default_nettype wire

### rtl/scsa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scsa_ctrl: sequencer
// Clears the accumulators after reset, then takes one beat at a time and
// steps the datapath through weight load, divide, taps and read-out.
// ----------------------------------------------------------------------------
module scsa_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  scsa_pkg::dp_stat_type    stat,
   output scsa_pkg::dp_cmd_type     cmd
);
   import scsa_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_DIV,
      S_TAP,
      S_DRAIN,
      S_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.opcode)
               OP_LOAD: begin
                  cmd.weight_write = 1'b1;
                  state_in         = S_IDLE;
               end
               OP_ACC: begin
                  if (stat.skip) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIV;
                  end
               end
               OP_READ: begin
                  cmd.read_issue = 1'b1;
                  state_in       = S_RESP;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_TAP;
         end
         S_TAP: begin
            cmd.tap_issue = 1'b1;
            if (stat.tap_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!stat.pipe_busy) state_in = S_IDLE;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.read_commit = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

`ifndef SYNTHESIS
   a_tap_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && stat.div_last) |=> (state_ff == S_TAP))
      else $error("taps did not follow the last divide step");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");
   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !stat.pipe_busy)
      else $error("tap pipeline busy while idle");
`endif

endmodule
`default_nettype wire

### rtl/scsa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scsa_datapath: weight store, divider, tap pipeline and accumulators
// Serial restoring divide of the lowered index, then one tap per cycle
// through read, multiply and read-modify-write of the accumulator memory.
// ----------------------------------------------------------------------------
module scsa_datapath (
   input  wire                        clock,
   input  wire                        reset,
   input  scsa_pkg::cfg_type          cfg,
   input  scsa_pkg::dp_cmd_type       cmd,
   output scsa_pkg::dp_stat_type      stat,
   input  wire [1:0]                  req_opcode,
   input  wire [4:0]                  req_out_column,
   input  wire [8:0]                  req_entry_index,
   input  wire signed [15:0]          req_entry_value,
   input  wire [5:0]                  req_weight_index,
   input  wire signed [15:0]          req_weight_value,
   input  wire [4:0]                  req_out_row,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic signed [39:0]         rsp_out_value
);
   import scsa_pkg::*;

   // saturated dimensions
   logic [KDIM_W-1:0] kh_sat, kw_sat;
   logic [ODIM_W-1:0] oh_sat, ow_sat;

   assign kh_sat = (cfg.kernel_h > KH_SAT) ? KH_SAT : cfg.kernel_h;
   assign kw_sat = (cfg.kernel_w > KW_SAT) ? KW_SAT : cfg.kernel_w;
   assign oh_sat = (cfg.out_h > OH_SAT) ? OH_SAT : cfg.out_h;
   assign ow_sat = (cfg.out_w > OW_SAT) ? OW_SAT : cfg.out_w;

   // captured beat
   op_type                   opcode_ff;
   logic [COL_W-1:0]         col_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic signed [VAL_W-1:0]  val_ff;
   logic [W_AW-1:0]          widx_ff;
   logic signed [VAL_W-1:0]  wval_ff;
   logic [ROW_W-1:0]         row_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff <= op_type'(req_opcode);
         col_ff    <= req_out_column;
         idx_ff    <= req_entry_index;
         val_ff    <= req_entry_value;
         widx_ff   <= req_weight_index;
         wval_ff   <= req_weight_value;
         row_ff    <= req_out_row;
      end
   end

   // divider: quo_ff shifts the dividend out and the quotient in
   logic [IDX_W-1:0]  quo_ff, quo_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DCNT_W-1:0] dcnt_ff;
   logic [REM_W:0]    div_shift;
   logic              div_ge;

   assign div_shift = {rem_ff, quo_ff[IDX_W-1]};
   assign div_ge    = (div_shift >= {1'b0, kw_sat});

   always_comb begin
      rem_in = div_ge ? REM_W'(div_shift - {1'b0, kw_sat}) : div_shift[REM_W-1:0];
      quo_in = {quo_ff[IDX_W-2:0], div_ge};
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff  <= idx_ff;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         dcnt_ff <= dcnt_ff + 1'b1;
      end
   end

   // tap sequencing
   logic [TAP_W-1:0] tap_ff;
   logic [OFF_W-1:0] off_ff;
   logic [OFF_W-1:0] tap_widx;
   logic [IDX_W-1:0] tap_diff;
   logic             tap_hit;
   logic [ACC_AW-1:0] tap_addr;

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         tap_ff <= '0;
         off_ff <= '0;
      end else if (cmd.tap_issue) begin
         tap_ff <= tap_ff + 1'b1;
         off_ff <= off_ff + OFF_W'(kw_sat);
      end
   end

   assign tap_widx = OFF_W'(rem_ff) + off_ff;
   assign tap_diff = quo_ff - IDX_W'(tap_ff);
   assign tap_hit  = (quo_ff >= IDX_W'(tap_ff)) && (tap_diff < IDX_W'(oh_sat))
                     && (tap_widx < OFF_W'(W_DEPTH));
   assign tap_addr = {tap_diff[ROW_W-1:0], col_ff};

   // weight store
   logic signed [VAL_W-1:0] wmem [W_DEPTH];
   logic signed [VAL_W-1:0] w_q_ff;

   always_ff @(posedge clock) begin
      if (cmd.weight_write) wmem[widx_ff] <= wval_ff;
      if (cmd.tap_issue) w_q_ff <= wmem[tap_widx[W_AW-1:0]];
   end

   // tap pipeline
   logic                     s1_valid_ff, s2_valid_ff;
   logic [ACC_AW-1:0]        s1_addr_ff, s2_addr_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [ACC_W-1:0]         acc_q_ff, acc_q2_ff;
   logic [ACC_W-1:0]         acc_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.tap_issue && tap_hit;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= tap_addr;
      s2_addr_ff <= s1_addr_ff;
      prod_ff    <= val_ff * w_q_ff;
      acc_q2_ff  <= acc_q_ff;
   end

   assign acc_sum = acc_q2_ff + ACC_W'(prod_ff);

   // accumulator memory, one write and one read port
   logic [ACC_W-1:0]  amem [ACC_DEPTH];
   logic [ACC_AW-1:0] clr_ff;
   logic              acc_we, acc_re;
   logic [ACC_AW-1:0] acc_wa, acc_ra;
   logic [ACC_W-1:0]  acc_wd;
   logic [ACC_AW-1:0] read_addr;

   assign read_addr = {row_ff, col_ff};
   assign acc_we    = cmd.clear_step || s2_valid_ff || cmd.read_commit;
   assign acc_re    = cmd.tap_issue || cmd.read_issue;
   assign acc_ra    = cmd.tap_issue ? tap_addr : read_addr;

   always_comb begin
      acc_wa = read_addr;
      acc_wd = '0;
      if (cmd.clear_step) begin
         acc_wa = clr_ff;
      end else if (s2_valid_ff) begin
         acc_wa = s2_addr_ff;
         acc_wd = acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_we) amem[acc_wa] <= acc_wd;
      if (acc_re) acc_q_ff <= amem[acc_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // result register
   logic                    rsp_valid_ff;
   logic signed [ACC_W-1:0] rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.read_commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_commit) rsp_value_ff <= acc_q_ff;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;

   always_comb begin
      stat.opcode     = opcode_ff;
      stat.skip       = (kh_sat == '0) || (kw_sat == '0) || ({1'b0, col_ff} >= ow_sat);
      stat.div_last   = (dcnt_ff == DCNT_W'(DIV_STEPS - 1));
      stat.tap_last   = ({1'b0, tap_ff} == (kh_sat - 1'b1));
      stat.pipe_busy  = s1_valid_ff || s2_valid_ff;
      stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
      stat.clear_last = &clr_ff;
   end

`ifndef SYNTHESIS
   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> $past(s1_valid_ff))
      else $error("write stage without a multiply stage before it");
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.read_commit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while held");
   a_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(s2_valid_ff && (cmd.clear_step || cmd.read_commit)))
      else $error("accumulator write port contention");
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) |-> (rem_ff < {1'b0, kw_sat[KDIM_W-2:0]} || kw_sat == KW_SAT))
      else $error("remainder not below divisor");
`endif

endmodule
`default_nettype wire

### rtl/sparse_conv_scatter_accumulate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_conv_scatter_accumulate: sparse convolution, scatter-accumulate
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// After reset the block zeroes the accumulator memory, one entry a cycle,
// with req_stall high; configuration writes are taken throughout. Beats are
// handled one at a time. A weight load is captured and then written; a read
// is captured, issued and then committed once the result register is free.
// A nonzero goes through a serial divide of the index by the kernel width,
// then one tap per cycle through the accumulator's one read port and one
// write port, then a drain of the tap pipeline, longest when the last tap
// lands inside the output height. Nonzeros that fall outside the output
// width, or meet a zero kernel dimension, are dropped after decode.
module sparse_conv_scatter_accumulate (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire [1:0]           req_opcode,
   input  wire [4:0]           req_out_column,
   input  wire [8:0]           req_entry_index,
   input  wire signed [15:0]   req_entry_value,
   input  wire [5:0]           req_weight_index,
   input  wire signed [15:0]   req_weight_value,
   input  wire [4:0]           req_out_row,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic signed [39:0]  rsp_out_value,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire [1:0]           csr_index,
   input  wire [5:0]           csr_data
);
   import scsa_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_KERNEL_H: cfg_in.kernel_h = csr_data[KDIM_W-1:0];
            CSR_KERNEL_W: cfg_in.kernel_w = csr_data[KDIM_W-1:0];
            CSR_OUT_H:    cfg_in.out_h    = csr_data[ODIM_W-1:0];
            CSR_OUT_W:    cfg_in.out_w    = csr_data[ODIM_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kernel_h <= KDIM_W'(1);
         cfg_ff.kernel_w <= KDIM_W'(7);
         cfg_ff.out_h    <= ODIM_W'(17);
         cfg_ff.out_w    <= ODIM_W'(11);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   scsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   scsa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_opcode),
      .req_out_column   (req_out_column),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .req_weight_index (req_weight_index),
      .req_weight_value (req_weight_value),
      .req_out_row      (req_out_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_value    (rsp_out_value)
   );

endmodule
`default_nettype wire

### dv/tb_sparse_conv_scatter_accumulate.sv
// ----------------------------------------------------------------------------
// tb_sparse_conv_scatter_accumulate: self-checking bench for the sparse
// convolution scatter-accumulate block
// Streams weight loads, nonzeros and read-and-clear beats through the block
// under a range of kernel and output geometries. Tests in-range, zero and
// saturating geometries, and 40-bit accumulator wrap. A shadow model of the
// weight and accumulator stores predicts every read, and each response is
// checked in order. Both channels idle at random, and the block is drained
// before each geometry change.
// ----------------------------------------------------------------------------
module tb_sparse_conv_scatter_accumulate;
   timeunit 1ns;
   timeprecision 1ps;

   import scsa_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         TAIL_CYCLES = 40;

   typedef struct {
      logic [1:0]         opcode;
      logic [4:0]         out_column;
      logic [8:0]         entry_index;
      logic signed [15:0] entry_value;
      logic [5:0]         weight_index;
      logic signed [15:0] weight_value;
      logic [4:0]         out_row;
   } conv_beat_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_opcode = '0;
   logic [4:0]          req_out_column = '0;
   logic [8:0]          req_entry_index = '0;
   logic signed [15:0]  req_entry_value = '0;
   logic [5:0]          req_weight_index = '0;
   logic signed [15:0]  req_weight_value = '0;
   logic [4:0]          req_out_row = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [39:0]  rsp_out_value;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [1:0]          csr_index = '0;
   logic [5:0]          csr_data = '0;

   sparse_conv_scatter_accumulate dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_out_column   (req_out_column),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .req_weight_index (req_weight_index),
      .req_weight_value (req_weight_value),
      .req_out_row      (req_out_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_value    (rsp_out_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // shadow of the block
   logic signed [VAL_W-1:0] weight_model [W_DEPTH];
   logic signed [ACC_W-1:0] acc_model [ACC_DEPTH];
   cfg_type                 model_cfg = '{kernel_h: 4'd1, kernel_w: 4'd7,
                                          out_h: 6'd17, out_w: 6'd11};
   logic signed [ACC_W-1:0] pending_sums [$];
   int unsigned             mismatches = 0;

   // stimulus side
   conv_beat_type pending_beats [$];
   cfg_type     gen_cfg = '{kernel_h: 4'd1, kernel_w: 4'd7, out_h: 6'd17, out_w: 6'd11};
   bit          weight_loaded [W_DEPTH];
   bit          calm = 1'b0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   conv_beat_type drv_beat;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("sparse_conv_scatter_accumulate verification failed");
      $finish;
   end

   function automatic void eff_dims(input cfg_type c, output int unsigned kh,
                                    output int unsigned kw, output int unsigned oh,
                                    output int unsigned ow);
      kh = (c.kernel_h > KH_SAT) ? KH_MAX : c.kernel_h;
      kw = (c.kernel_w > KW_SAT) ? KW_MAX : c.kernel_w;
      oh = (c.out_h > OH_SAT) ? OUT_H_MAX : c.out_h;
      ow = (c.out_w > OW_SAT) ? OUT_W_MAX : c.out_w;
   endfunction

   function automatic void enqueue_beat(input conv_beat_type b);
      pending_beats.insert(pending_beats.size(), b);
   endfunction

   function automatic void scatter_nonzero(input conv_beat_type b);
      int unsigned             kh, kw, oh, ow, q, r, m, widx, a, l;
      logic signed [PROD_W-1:0] prod;
      eff_dims(model_cfg, kh, kw, oh, ow);
      if (kh == 0 || kw == 0 || b.out_column >= ow) return;
      q = b.entry_index / kw;
      r = b.entry_index % kw;
      for (l = 0; l < kh; l++) begin
         widx = r + l * kw;
         if (q >= l && (q - l) < oh && widx < W_DEPTH) begin
            m    = q - l;
            a    = m * OUT_W_MAX + b.out_column;
            prod = b.entry_value * weight_model[widx];
            acc_model[a] = acc_model[a] + prod;
         end
      end
   endfunction

   function automatic void update_conv_model(input conv_beat_type b);
      int unsigned a;
      case (b.opcode)
         OP_LOAD: begin
            weight_model[b.weight_index] = b.weight_value;
         end
         OP_ACC: begin
            scatter_nonzero(b);
         end
         OP_READ: begin
            a = b.out_row * OUT_W_MAX + b.out_column;
            pending_sums.insert(pending_sums.size(), acc_model[a]);
            acc_model[a] = '0;
         end
         default: begin
         end
      endcase
   endfunction

   initial begin
      foreach (acc_model[i]) acc_model[i] = '0;
      foreach (weight_model[i]) weight_model[i] = '0;
      foreach (weight_loaded[i]) weight_loaded[i] = 1'b0;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_beats.size() != 0) begin
            drv_beat = pending_beats.pop_front();
            req_opcode       <= drv_beat.opcode;
            req_out_column   <= drv_beat.out_column;
            req_entry_index  <= drv_beat.entry_index;
            req_entry_value  <= drv_beat.entry_value;
            req_weight_index <= drv_beat.weight_index;
            req_weight_value <= drv_beat.weight_value;
            req_out_row      <= drv_beat.out_row;
            req_valid        <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: check responses first, then predict the accepted beat
   always @(posedge clock) begin
      conv_beat_type           seen;
      logic signed [ACC_W-1:0] want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_KERNEL_H: model_cfg.kernel_h = csr_data[KDIM_W-1:0];
               CSR_KERNEL_W: model_cfg.kernel_w = csr_data[KDIM_W-1:0];
               CSR_OUT_H:    model_cfg.out_h    = csr_data;
               CSR_OUT_W:    model_cfg.out_w    = csr_data;
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_sums.size() == 0) begin
               $display("%0t: out_value unexpected beat, expected none actual %0d",
                        $time, rsp_out_value);
               mismatches++;
            end else begin
               want = pending_sums.pop_front();
               if (rsp_out_value !== want) begin
                  $display("%0t: out_value mismatch, expected %0d actual %0d",
                           $time, want, rsp_out_value);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            seen.opcode       = req_opcode;
            seen.out_column   = req_out_column;
            seen.entry_index  = req_entry_index;
            seen.entry_value  = req_entry_value;
            seen.weight_index = req_weight_index;
            seen.weight_value = req_weight_value;
            seen.out_row      = req_out_row;
            update_conv_model(seen);
         end
      end
   end

   function automatic conv_beat_type random_beat();
      conv_beat_type b;
      b.opcode       = 2'($urandom_range(0, 3));
      b.out_column   = 5'($urandom);
      b.entry_index  = 9'($urandom);
      b.entry_value  = 16'($urandom);
      b.weight_index = 6'($urandom);
      b.weight_value = 16'($urandom);
      b.out_row      = 5'($urandom);
      return b;
   endfunction

   function automatic void queue_load(input int unsigned widx, input logic signed [15:0] wval);
      conv_beat_type b;
      b              = random_beat();
      b.opcode       = OP_LOAD;
      b.weight_index = 6'(widx);
      b.weight_value = wval;
      weight_loaded[widx] = 1'b1;
      enqueue_beat(b);
   endfunction

   function automatic void queue_read(input int unsigned row, input int unsigned col);
      conv_beat_type b;
      b            = random_beat();
      b.opcode     = OP_READ;
      b.out_row    = 5'(row);
      b.out_column = 5'(col);
      enqueue_beat(b);
   endfunction

   // every weight a nonzero will touch is loaded ahead of it
   function automatic void queue_nonzero(input conv_beat_type b);
      int unsigned kh, kw, oh, ow, q, r, widx, l;
      b.opcode = OP_ACC;
      eff_dims(gen_cfg, kh, kw, oh, ow);
      if (kh != 0 && kw != 0 && b.out_column < ow) begin
         q = b.entry_index / kw;
         r = b.entry_index % kw;
         for (l = 0; l < kh; l++) begin
            widx = r + l * kw;
            if (q >= l && (q - l) < oh && !weight_loaded[widx])
               queue_load(widx, 16'($urandom));
         end
      end
      enqueue_beat(b);
   endfunction

   task automatic write_csr(input csr_idx_type idx, input int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DAT_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_dims(input int unsigned kh, input int unsigned kw,
                           input int unsigned oh, input int unsigned ow);
      write_csr(CSR_KERNEL_H, kh);
      write_csr(CSR_KERNEL_W, kw);
      write_csr(CSR_OUT_H, oh);
      write_csr(CSR_OUT_W, ow);
      gen_cfg.kernel_h = KDIM_W'(kh);
      gen_cfg.kernel_w = KDIM_W'(kw);
      gen_cfg.out_h    = ODIM_W'(oh);
      gen_cfg.out_w    = ODIM_W'(ow);
   endtask

   // sampled away from the rising edge so the driver's updates have settled
   task automatic drain_block();
      while (pending_beats.size() != 0 || req_valid || pending_sums.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int unsigned count);
      conv_beat_type b;
      int unsigned kh, kw, oh, ow, pick, idx;
      eff_dims(gen_cfg, kh, kw, oh, ow);
      repeat (count) begin
         b    = random_beat();
         pick = $urandom_range(0, 99);
         if (ow != 0 && $urandom_range(0, 6) != 0) b.out_column = 5'($urandom_range(0, ow - 1));
         if (pick < 12) begin
            b.opcode = OP_LOAD;
            weight_loaded[b.weight_index] = 1'b1;
            enqueue_beat(b);
         end else if (pick < 62) begin
            if (kw != 0 && $urandom_range(0, 4) != 0) begin
               idx = $urandom_range(0, oh + kh) * kw + $urandom_range(0, kw - 1);
               b.entry_index = (idx > 511) ? 9'($urandom) : 9'(idx);
            end
            queue_nonzero(b);
         end else if (pick < 96) begin
            b.opcode = OP_READ;
            if (oh != 0 && $urandom_range(0, 6) != 0) b.out_row = 5'($urandom_range(0, oh - 1));
            enqueue_beat(b);
         end else begin
            b.opcode = OP_UNUSED;
            enqueue_beat(b);
         end
      end
   endtask

   initial begin
      conv_beat_type b;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, ignored columns, taps off the bottom, unused opcode
      set_dims(8, 8, 32, 11);
      queue_load(0, -16'sd32768);
      queue_load(63, 16'sd32767);
      b = random_beat();
      b.out_column = 5'd0; b.entry_index = 9'd0; b.entry_value = -16'sd32768;
      queue_nonzero(b);
      b = random_beat();
      b.out_column = 5'd10; b.entry_index = 9'd511; b.entry_value = 16'sd32767;
      queue_nonzero(b);
      b = random_beat();
      b.out_column = 5'd10; b.entry_index = 9'd255; b.entry_value = 16'sd32767;
      queue_nonzero(b);
      b = random_beat();
      b.out_column = 5'd31; b.entry_index = 9'd8; b.entry_value = 16'sd32767;
      queue_nonzero(b);
      b.opcode = OP_UNUSED; b.out_column = '1; b.entry_index = '1; b.entry_value = -16'sd1;
      b.weight_index = '1; b.weight_value = -16'sd1; b.out_row = '1;
      enqueue_beat(b);
      queue_read(0, 0);
      queue_read(31, 10);
      queue_read(24, 10);
      queue_read(31, 31);
      queue_read(0, 0);
      drain_block();

      // accumulator wrap: 520 full-scale products into one cell
      set_dims(1, 1, 1, 1);
      queue_load(0, -16'sd32768);
      repeat (520) begin
         b = random_beat();
         b.out_column = 5'd0; b.entry_index = 9'd0; b.entry_value = -16'sd32768;
         queue_nonzero(b);
      end
      queue_read(0, 0);
      drain_block();

      set_dims(8, 8, 32, 32);
      run_random(80);
      drain_block();
      set_dims(15, 15, 63, 63);
      run_random(60);
      drain_block();
      set_dims(1, 7, 17, 11);
      run_random(60);
      drain_block();
      set_dims(0, 3, 5, 9);
      run_random(30);
      drain_block();
      set_dims(3, 0, 8, 8);
      run_random(30);
      drain_block();
      set_dims(4, 5, 0, 0);
      run_random(20);
      drain_block();
      repeat (6) begin
         set_dims($urandom_range(1, 8), $urandom_range(1, 8),
                  $urandom_range(1, 32), $urandom_range(1, 32));
         run_random(25);
         drain_block();
         run_random(25);
         drain_block();
      end

      calm = 1'b1;
      set_dims($urandom_range(1, 8), $urandom_range(1, 8),
               $urandom_range(1, 32), $urandom_range(1, 32));
      run_random(60);
      drain_block();

      if (mismatches == 0 && pending_sums.size() == 0)
         $display("sparse_conv_scatter_accumulate verification clean");
      else
         $display("sparse_conv_scatter_accumulate verification failed");
      $finish;
   end

endmodule

### files.f
rtl/scsa_pkg.sv
rtl/scsa_ctrl.sv
rtl/scsa_datapath.sv
rtl/sparse_conv_scatter_accumulate.sv
dv/tb_sparse_conv_scatter_accumulate.sv
